// ----- sv/dbre_pkg.sv -----
// ----------------------------------------------------------------------------
// dbre_pkg: shared types and constants for the debounce and encoder core
// Transfer payload types, channel codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package dbre_pkg;

   localparam int NUM_CHANNELS    = 7;
   localparam int CHANNEL_WIDTH   = 3;
   localparam int TIME_WIDTH      = 32;
   localparam int POSITION_WIDTH  = 16;
   localparam int NUM_BUTTONS     = 4;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CHANNEL_WIDTH-1:0] CH_GREEN    = 3'd0;
   localparam logic [CHANNEL_WIDTH-1:0] CH_BLUE     = 3'd1;
   localparam logic [CHANNEL_WIDTH-1:0] CH_RED      = 3'd2;
   localparam logic [CHANNEL_WIDTH-1:0] CH_YELLOW   = 3'd3;
   localparam logic [CHANNEL_WIDTH-1:0] CH_CLOCK    = 3'd4;
   localparam logic [CHANNEL_WIDTH-1:0] CH_DATA     = 3'd5;
   localparam logic [CHANNEL_WIDTH-1:0] CH_SWITCH   = 3'd6;
   localparam logic [CHANNEL_WIDTH-1:0] CH_NONE     = 3'd7;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_INTERVAL = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POSITION_MAX      = 1'd1;

   localparam logic [TIME_WIDTH-1:0]     DEBOUNCE_RESET     = 32'd50000;
   localparam logic [POSITION_WIDTH-1:0] POSITION_MAX_RESET = 16'd30;

   typedef struct packed {
      logic [CHANNEL_WIDTH-1:0] channel;
      logic [TIME_WIDTH-1:0]    time_us;
      logic                     clock_level;
      logic                     data_level;
   } req_type;

   typedef struct packed {
      logic                      accepted;
      logic                      green_pressed;
      logic                      blue_pressed;
      logic                      red_pressed;
      logic                      yellow_pressed;
      logic                      knob_pressed;
      logic [POSITION_WIDTH-1:0] position;
   } rsp_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]     debounce_interval_us;
      logic [POSITION_WIDTH-1:0] position_max;
   } cfg_type;

endpackage

`default_nettype wire

// ----- sv/dbre_state.sv -----
// ----------------------------------------------------------------------------
// dbre_state: debounce check and channel state update
// Holds the per-channel last accepted times, the button and switch flags and
// the encoder position, and forms the result of the event being processed.
// ----------------------------------------------------------------------------
`default_nettype none

module dbre_state (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             update_en,
   input  wire dbre_pkg::req_type event_data,
   input  wire dbre_pkg::cfg_type cfg,
   output dbre_pkg::rsp_type     result
);

   logic [dbre_pkg::TIME_WIDTH-1:0]     last_time_ff [dbre_pkg::NUM_CHANNELS];
   logic [dbre_pkg::NUM_BUTTONS-1:0]    buttons_ff;
   logic [dbre_pkg::NUM_BUTTONS-1:0]    buttons_in;
   logic                                knob_ff;
   logic                                knob_in;
   logic [dbre_pkg::POSITION_WIDTH-1:0] count_ff;
   logic [dbre_pkg::POSITION_WIDTH-1:0] count_in;

   logic                                channel_ok;
   logic [dbre_pkg::TIME_WIDTH-1:0]     last_time;
   logic [dbre_pkg::TIME_WIDTH-1:0]     distance;
   logic                                hit;

   assign channel_ok = event_data.channel != dbre_pkg::CH_NONE;

   always_comb begin
      last_time = '0;
      if (channel_ok) begin
         last_time = last_time_ff[event_data.channel];
      end
   end

   assign distance = event_data.time_us - last_time;
   assign hit      = channel_ok && (distance >= cfg.debounce_interval_us);

   always_comb begin
      buttons_in = buttons_ff;
      knob_in    = knob_ff;
      count_in   = count_ff;
      if (hit) begin
         case (event_data.channel)
            dbre_pkg::CH_GREEN, dbre_pkg::CH_BLUE,
            dbre_pkg::CH_RED, dbre_pkg::CH_YELLOW: begin
               buttons_in[event_data.channel[1:0]] = ~buttons_ff[event_data.channel[1:0]];
            end
            dbre_pkg::CH_SWITCH: begin
               knob_in = ~knob_ff;
            end
            dbre_pkg::CH_CLOCK: begin
               if (event_data.clock_level != event_data.data_level) begin
                  if (count_ff < cfg.position_max) begin
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dbre_pkg::NUM_CHANNELS; i++) begin
            last_time_ff[i] <= '0;
         end
         buttons_ff <= '0;
         knob_ff    <= 1'b0;
         count_ff   <= '0;
      end else if (update_en) begin
         if (hit) begin
            last_time_ff[event_data.channel] <= event_data.time_us;
         end
         buttons_ff <= buttons_in;
         knob_ff    <= knob_in;
         count_ff   <= count_in;
      end
   end

   always_comb begin
      result.accepted       = hit;
      result.green_pressed  = buttons_in[0];
      result.blue_pressed   = buttons_in[1];
      result.red_pressed    = buttons_in[2];
      result.yellow_pressed = buttons_in[3];
      result.knob_pressed   = knob_in;
      result.position       = count_in;
   end

endmodule

`default_nettype wire

// ----- sv/debounced_buttons_and_rotary_encoder_core.sv -----
// ----------------------------------------------------------------------------
// debounced_buttons_and_rotary_encoder_core: debounced buttons and encoder
// Each pin edge event on the request channel yields one result transfer with
// the debounce verdict, the button and switch states and the knob position.
//
// The request channel carries channel number, timestamp and the sampled
// encoder levels; a transfer happens when req_valid is high and req_stall low.
// The event is registered in the input register, then checked and applied to
// the channel state when it advances, and the result is registered. One event
// is taken every cycle while rsp_stall is low; the state update is a compare
// and add or subtract between the input and result registers.
// When the receiver holds rsp_stall, the result register keeps its transfer
// and the input register fills, after which req_stall rises until the result
// leaves. The csr port writes the debounce interval and the position limit
// at any edge where csr_write_enable is high and reset is low.
// Synchronous reset empties both registers, clears all stored times, flags
// and the position, and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_buttons_and_rotary_encoder_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire dbre_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output dbre_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_write_enable,
   input  wire logic [dbre_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [dbre_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   dbre_pkg::cfg_type cfg_ff;
   dbre_pkg::req_type s1_data_ff;
   logic              s1_valid_ff;
   dbre_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff;
   dbre_pkg::rsp_type result;
   logic              advance;
   logic              req_take;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_interval_us <= dbre_pkg::DEBOUNCE_RESET;
         cfg_ff.position_max         <= dbre_pkg::POSITION_MAX_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            dbre_pkg::CSR_DEBOUNCE_INTERVAL: begin
               cfg_ff.debounce_interval_us <= csr_write_data;
            end
            dbre_pkg::CSR_POSITION_MAX: begin
               cfg_ff.position_max <= csr_write_data[dbre_pkg::POSITION_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   dbre_state u_state (
      .clock      (clock),
      .reset      (reset),
      .update_en  (advance),
      .event_data (s1_data_ff),
      .cfg        (cfg_ff),
      .result     (result)
   );

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed event produced no result");

   a_no_channel_rejected: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_data_ff.channel == dbre_pkg::CH_NONE) |=> !rsp_data.accepted)
      else $error("event on missing channel was accepted");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("input register changed while stalled");

endmodule

`default_nettype wire
